// ===== src/demppt_pkg.sv =====
// Package: payload types and constants for the differential evolution MPPT unit
`default_nettype none
package demppt_pkg;
    localparam int unsigned FracW = 17;
    localparam int unsigned PowW  = 32;
    localparam logic [FracW-1:0] OneQ16 = 17'h10000;

    localparam logic [2:0] CfgDutyBits  = 3'd0;
    localparam logic [2:0] CfgMutFactor = 3'd1;
    localparam logic [2:0] CfgCrossRate = 3'd2;
    localparam logic [2:0] CfgSpread    = 3'd3;
    localparam logic [2:0] CfgStartA    = 3'd4;
    localparam logic [2:0] CfgStartB    = 3'd5;
    localparam logic [2:0] CfgStartC    = 3'd6;

    localparam logic [1:0] TaskSend    = 2'd0;
    localparam logic [1:0] TaskCall    = 2'd1;
    localparam logic [1:0] TaskMeasure = 2'd2;

    typedef struct packed {
        logic        allowed;
        logic [31:0] power_mw;
        logic [2:0]  shuffle_code_a;
        logic [2:0]  shuffle_code_b;
        logic [2:0]  shuffle_code_c;
        logic [15:0] cross_draw_a;
        logic [15:0] cross_draw_b;
        logic [15:0] cross_draw_c;
    } in_item_t;

    typedef struct packed {
        logic        duty_update;
        logic [15:0] duty_value;
        logic [1:0]  task_next;
        logic        finished;
        logic        final_valid;
        logic [31:0] final_power_mw;
    } out_item_t;

    function automatic logic [FracW-1:0] sat_one(input logic [FracW-1:0] v);
        return (v > OneQ16) ? OneQ16 : v;
    endfunction
endpackage
`default_nettype wire

// ===== src/differential_evolution_mppt_unit.sv =====
// Top level: differential evolution MPPT tracker with a shared multiplier sequencer
`default_nettype none
// One request is one tracker call. The block works on one request at a time.
// For the plain stages the result passes through the dispatch and output states.
// A duty stage sends its duty value through the shared 17x17 multiplier, and
// selection makes two passes over the three candidates, then one duty computation.
// The mutate stage runs the multiplier once per candidate. A finished result sits
// in its own register, so the block can take the next request while that result
// waits for m_ready. It then holds its own result until the register is free.
module differential_evolution_mppt_unit import demppt_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_data,
    input  wire logic      cfg_valid,
    output logic           cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_MUL, S_DUTY, S_MUT_PICK, S_MUT_MUL, S_MUT_APPLY,
        S_SEL, S_SEL_BEST, S_SPREAD, S_OUT
    } fsm_t;

    // tracker stages
    localparam logic [3:0] StgSetup      = 4'd0;
    localparam logic [3:0] StgSetDuty    = 4'd1;
    localparam logic [3:0] StgCheckPower = 4'd2;
    localparam logic [3:0] StgMutate     = 4'd3;
    localparam logic [3:0] StgSetTrial   = 4'd4;
    localparam logic [3:0] StgCheckTrial = 4'd5;
    localparam logic [3:0] StgSelect     = 4'd6;
    localparam logic [3:0] StgSpread     = 4'd7;
    localparam logic [3:0] StgFinal      = 4'd8;

    localparam out_item_t CallResult = '{duty_update: 1'b0, duty_value: '0,
                                         task_next: TaskCall, finished: 1'b0,
                                         final_valid: 1'b0, final_power_mw: '0};
    localparam out_item_t DoneResult = '{duty_update: 1'b0, duty_value: '0,
                                         task_next: TaskSend, finished: 1'b1,
                                         final_valid: 1'b0, final_power_mw: '0};

    logic [4:0]       duty_bits_reg;
    logic [FracW-1:0] mut_f_reg, cross_r_reg, start_a_reg, start_b_reg, start_c_reg;
    logic [31:0]      spread_reg;

    fsm_t             state_reg;
    logic [3:0]       stage_reg;
    logic [1:0]       cursor_reg;
    logic [FracW-1:0] pop_f_reg [3];
    logic [PowW-1:0]  pop_p_reg [3];
    logic [FracW-1:0] trial_f_reg [3];
    logic [PowW-1:0]  trial_p_reg [3];
    logic [FracW-1:0] best_f_reg;
    logic [PowW-1:0]  best_p_reg;
    in_item_t         in_reg;
    out_item_t        out_reg;
    out_item_t        res_reg;
    logic             m_valid_reg;
    logic [1:0]       k_reg;
    logic             improved_reg;
    logic [PowW-1:0]  lo_reg, hi_reg;
    logic [FracW-1:0] base_reg, mula_reg, mulb_reg;
    logic [33:0]      prod_reg;
    logic [15:0]      top_reg;

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = res_reg;

    // shared multiplier
    logic [33:0] prod_w;
    assign prod_w = 34'(mula_reg) * 34'(mulb_reg);

    logic [1:0] slot_w;
    assign slot_w = (cursor_reg > 2'd2) ? 2'd2 : cursor_reg;

    logic [4:0] bits_w;
    assign bits_w = (duty_bits_reg < 5'd2) ? 5'd2 :
                    ((duty_bits_reg > 5'd16) ? 5'd16 : duty_bits_reg);
    logic [15:0] top_w;
    assign top_w = 16'((17'd1 << bits_w) - 17'd1);

    logic [15:0] duty_w;
    always_comb begin
        if (mula_reg >= OneQ16)  duty_w = top_reg;
        else if (mula_reg == '0) duty_w = 16'd1;
        else                     duty_w = 16'd1 + prod_reg[31:16];
    end

    // mutation donor selection for candidate k_reg
    logic [2:0]  code_w;
    logic [1:0]  p_w [3];
    logic [1:0]  j_w, t_w;
    logic [15:0] draw_w;
    always_comb begin
        unique case (k_reg)
            2'd0:    begin code_w = in_reg.shuffle_code_a; draw_w = in_reg.cross_draw_a; end
            2'd1:    begin code_w = in_reg.shuffle_code_b; draw_w = in_reg.cross_draw_b; end
            default: begin code_w = in_reg.shuffle_code_c; draw_w = in_reg.cross_draw_c; end
        endcase
        p_w[0] = 2'd0; p_w[1] = 2'd1; p_w[2] = 2'd2;
        j_w = (code_w[2:1] > 2'd2) ? 2'd2 : code_w[2:1];
        t_w = p_w[2]; p_w[2] = p_w[j_w]; p_w[j_w] = t_w;
        j_w = {1'b0, code_w[0]};
        t_w = p_w[1]; p_w[1] = p_w[j_w]; p_w[j_w] = t_w;
    end
    logic [FracW-1:0] d1_w, d2_w, diff_w;
    assign d1_w   = pop_f_reg[p_w[1]];
    assign d2_w   = pop_f_reg[p_w[2]];
    assign diff_w = (d1_w > d2_w) ? d1_w - d2_w : d2_w - d1_w;

    logic [FracW-1:0] step_w;
    logic [18:0]      sum_w;
    logic [FracW-1:0] mut_w;
    logic [17:0]      d2x_w;
    logic             take_w;
    logic [FracW-1:0] cr_w;
    assign step_w = prod_reg[32:16];
    assign sum_w  = 19'(base_reg) + 19'(step_w);
    assign cr_w   = sat_one(cross_r_reg);
    assign d2x_w  = {draw_w, 1'b0} ;
    assign take_w = (d2x_w >= 18'(cr_w)) && (d2x_w <= 18'h20000 - 18'(cr_w));
    always_comb begin
        if (base_reg >= best_f_reg)
            mut_w = (step_w > base_reg) ? '0 : base_reg - step_w;
        else
            mut_w = (sum_w >= 19'(OneQ16)) ? OneQ16 : sum_w[FracW-1:0];
    end

    logic [FracW-1:0] duty_f_w;
    always_comb begin
        unique case (stage_reg)
            StgSetDuty:  duty_f_w = pop_f_reg[slot_w];
            StgSetTrial: duty_f_w = trial_f_reg[slot_w];
            default:     duty_f_w = best_f_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            duty_bits_reg <= 5'd10;
            mut_f_reg     <= 17'd52429;
            cross_r_reg   <= 17'd13107;
            spread_reg    <= 32'd5000;
            start_a_reg   <= 17'd19661;
            start_b_reg   <= 17'd39322;
            start_c_reg   <= 17'd58982;
            state_reg     <= S_IDLE;
            stage_reg     <= StgSetup;
            cursor_reg    <= '0;
            pop_f_reg[0]  <= 17'd19661;
            pop_f_reg[1]  <= 17'd39322;
            pop_f_reg[2]  <= 17'd58982;
            for (int i = 0; i < 3; i++) begin
                pop_p_reg[i]   <= '0;
                trial_f_reg[i] <= '0;
                trial_p_reg[i] <= '0;
            end
            best_f_reg   <= '0;
            best_p_reg   <= '0;
            m_valid_reg  <= 1'b0;
            k_reg        <= '0;
            improved_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    CfgDutyBits:  duty_bits_reg <= cfg_data[4:0];
                    CfgMutFactor: mut_f_reg     <= cfg_data[16:0];
                    CfgCrossRate: cross_r_reg   <= cfg_data[16:0];
                    CfgSpread:    spread_reg    <= cfg_data;
                    CfgStartA:    start_a_reg   <= cfg_data[16:0];
                    CfgStartB:    start_b_reg   <= cfg_data[16:0];
                    CfgStartC:    start_c_reg   <= cfg_data[16:0];
                    default: ;
                endcase
            end
            if (state_reg == S_OUT && (!m_valid_reg || m_ready)) m_valid_reg <= 1'b1;
            else if (m_valid_reg && m_ready)                      m_valid_reg <= 1'b0;
            prod_reg <= prod_w;
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid && s_ready) begin
                        in_reg    <= s_data;
                        state_reg <= S_DISPATCH;
                    end
                end
                S_DISPATCH: begin
                    state_reg <= S_OUT;
                    case (stage_reg)
                        StgSetup: begin
                            if (!in_reg.allowed) begin
                                out_reg <= DoneResult;
                            end else begin
                                out_reg <= CallResult;
                                pop_f_reg[0] <= sat_one(start_a_reg);
                                pop_f_reg[1] <= sat_one(start_b_reg);
                                pop_f_reg[2] <= sat_one(start_c_reg);
                                for (int i = 0; i < 3; i++) begin
                                    pop_p_reg[i]   <= '0;
                                    trial_f_reg[i] <= '0;
                                    trial_p_reg[i] <= '0;
                                end
                                cursor_reg <= '0;
                                best_f_reg <= '0;
                                best_p_reg <= '0;
                                stage_reg  <= StgSetDuty;
                            end
                        end
                        StgSetDuty, StgSetTrial: begin
                            out_reg   <= CallResult;
                            mula_reg  <= duty_f_w;
                            mulb_reg  <= 17'(top_w - 16'd1);
                            top_reg   <= top_w;
                            state_reg <= S_MUL;
                        end
                        StgCheckPower: begin
                            out_reg <= CallResult;
                            pop_p_reg[slot_w] <= in_reg.power_mw;
                            if (in_reg.power_mw > best_p_reg) begin
                                best_p_reg <= in_reg.power_mw;
                                best_f_reg <= pop_f_reg[slot_w];
                            end
                            cursor_reg <= (cursor_reg >= 2'd2) ? 2'd0 : cursor_reg + 2'd1;
                            stage_reg  <= (cursor_reg >= 2'd2) ? StgMutate : StgSetDuty;
                        end
                        StgMutate: begin
                            out_reg   <= CallResult;
                            k_reg     <= '0;
                            state_reg <= S_MUT_PICK;
                        end
                        StgCheckTrial: begin
                            out_reg <= CallResult;
                            trial_p_reg[slot_w] <= in_reg.power_mw;
                            cursor_reg <= (cursor_reg >= 2'd2) ? 2'd0 : cursor_reg + 2'd1;
                            stage_reg  <= (cursor_reg >= 2'd2) ? StgSelect : StgSetTrial;
                        end
                        StgSelect: begin
                            out_reg      <= CallResult;
                            k_reg        <= '0;
                            improved_reg <= 1'b0;
                            state_reg    <= S_SEL;
                        end
                        StgSpread: begin
                            out_reg   <= CallResult;
                            k_reg     <= 2'd1;
                            lo_reg    <= pop_p_reg[0];
                            hi_reg    <= pop_p_reg[0];
                            state_reg <= S_SPREAD;
                        end
                        StgFinal: begin
                            out_reg <= '{duty_update: 1'b0, duty_value: '0,
                                         task_next: TaskSend, finished: 1'b1,
                                         final_valid: 1'b1,
                                         final_power_mw: in_reg.power_mw};
                            stage_reg <= StgSetup;
                        end
                        default: begin
                            out_reg   <= CallResult;
                            stage_reg <= StgSetup;
                        end
                    endcase
                end
                S_MUL: state_reg <= S_DUTY;
                S_DUTY: begin
                    out_reg <= '{duty_update: 1'b1, duty_value: duty_w,
                                 task_next: (stage_reg == StgSetDuty ||
                                             stage_reg == StgSetTrial) ?
                                            TaskMeasure : out_reg.task_next,
                                 finished: 1'b0, final_valid: 1'b0, final_power_mw: '0};
                    if (stage_reg == StgSetDuty)       stage_reg <= StgCheckPower;
                    else if (stage_reg == StgSetTrial) stage_reg <= StgCheckTrial;
                    state_reg <= S_OUT;
                end
                S_MUT_PICK: begin
                    base_reg  <= pop_f_reg[p_w[0]];
                    mula_reg  <= sat_one(mut_f_reg);
                    mulb_reg  <= diff_w;
                    state_reg <= S_MUT_MUL;
                end
                S_MUT_MUL: state_reg <= S_MUT_APPLY;
                S_MUT_APPLY: begin
                    trial_f_reg[k_reg] <= take_w ? mut_w : pop_f_reg[k_reg];
                    if (k_reg == 2'd2) begin
                        stage_reg <= StgSetTrial;
                        state_reg <= S_OUT;
                    end else begin
                        k_reg     <= k_reg + 2'd1;
                        state_reg <= S_MUT_PICK;
                    end
                end
                S_SEL: begin
                    if (trial_p_reg[k_reg] > pop_p_reg[k_reg]) begin
                        pop_f_reg[k_reg] <= trial_f_reg[k_reg];
                        pop_p_reg[k_reg] <= trial_p_reg[k_reg];
                        improved_reg     <= 1'b1;
                    end
                    if (k_reg == 2'd2) begin
                        k_reg      <= '0;
                        best_p_reg <= '0;
                        state_reg  <= S_SEL_BEST;
                    end else k_reg <= k_reg + 2'd1;
                end
                S_SEL_BEST: begin
                    if (pop_p_reg[k_reg] > best_p_reg) begin
                        best_p_reg <= pop_p_reg[k_reg];
                        best_f_reg <= pop_f_reg[k_reg];
                    end
                    if (k_reg == 2'd2) begin
                        stage_reg <= improved_reg ? StgSpread : StgFinal;
                        out_reg.task_next <= improved_reg ? TaskCall : TaskMeasure;
                        state_reg <= S_MUL;
                        mula_reg  <= (pop_p_reg[2] > best_p_reg) ? pop_f_reg[2] : best_f_reg;
                        mulb_reg  <= 17'(top_w - 16'd1);
                        top_reg   <= top_w;
                    end else k_reg <= k_reg + 2'd1;
                end
                S_SPREAD: begin
                    if (pop_p_reg[k_reg] > hi_reg) hi_reg <= pop_p_reg[k_reg];
                    if (pop_p_reg[k_reg] < lo_reg) lo_reg <= pop_p_reg[k_reg];
                    if (k_reg == 2'd2) begin
                        state_reg <= S_OUT;
                        k_reg     <= '0;
                        if (((pop_p_reg[2] > hi_reg) ? pop_p_reg[2] : hi_reg) -
                            ((pop_p_reg[2] < lo_reg) ? pop_p_reg[2] : lo_reg) < spread_reg) begin
                            stage_reg <= StgFinal;
                            out_reg.task_next <= TaskMeasure;
                        end else stage_reg <= StgMutate;
                    end else k_reg <= k_reg + 2'd1;
                end
                S_OUT: begin
                    // wait here while the previous result still holds the register
                    if (!m_valid_reg || m_ready) begin
                        res_reg   <= out_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
